// ===== src/smx_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the stack machine.
package smx_pkg;

   localparam int DEF_STACK_DEPTH = 256;
   localparam int DEF_PROG_DEPTH  = 1024;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 7;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_W      = 10;

   localparam logic [4:0] CMD_READ    = 5'd0;
   localparam logic [4:0] CMD_WRITE   = 5'd1;
   localparam logic [4:0] CMD_DUPE    = 5'd2;
   localparam logic [4:0] CMD_PUSH    = 5'd3;
   localparam logic [4:0] CMD_ADD     = 5'd4;
   localparam logic [4:0] CMD_SUB     = 5'd5;
   localparam logic [4:0] CMD_MUL     = 5'd6;
   localparam logic [4:0] CMD_DIV     = 5'd7;
   localparam logic [4:0] CMD_AND     = 5'd8;
   localparam logic [4:0] CMD_OR      = 5'd9;
   localparam logic [4:0] CMD_XOR     = 5'd10;
   localparam logic [4:0] CMD_REVERSE = 5'd11;
   localparam logic [4:0] CMD_JEQ     = 5'd12;
   localparam logic [4:0] CMD_JGT     = 5'd13;
   localparam logic [4:0] CMD_JMP     = 5'd14;
   localparam logic [4:0] CMD_CALL    = 5'd15;
   localparam logic [4:0] CMD_RET     = 5'd16;
   localparam logic [4:0] CMD_SIZE    = 5'd17;
   localparam logic [4:0] CMD_EMPTY   = 5'd18;
   localparam logic [4:0] CMD_HALT    = 5'd19;

   localparam logic [1:0] REV_POPPED = 2'd1;
   localparam logic [1:0] REV_IMM    = 2'd2;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
   localparam logic [2:0] ERR_DIV_ZERO  = 3'd3;
   localparam logic [2:0] ERR_BAD_RET   = 3'd4;

   typedef enum logic [1:0] {
      RD_TOP,
      RD_SECOND,
      RD_LO,
      RD_HI
   } rd_sel_type;

   typedef struct packed {
      logic       load;
      rd_sel_type rd_sel;
      logic       cap_a;
      logic       exec;
      logic       div_step;
      logic       div_wr;
      logic       rev_cap;
      logic       rev_w1;
      logic       rev_w2;
      logic       finish;
   } smx_cmd_type;

   typedef struct packed {
      logic rsp_busy;
      logic long_div;
      logic long_rev;
      logic div_last;
      logic rev_more;
   } smx_status_type;

endpackage

// ===== src/smx_ctrl.sv =====
// Sequencing state machine of the stack machine execute unit.
module smx_ctrl
   import smx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  smx_status_type status,
   output smx_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_A,
      S_RD_B,
      S_EXEC,
      S_DIV,
      S_DIV_WR,
      S_REV_CHK,
      S_REV_RD1,
      S_REV_RD2,
      S_REV_W1,
      S_REV_W2
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_TOP;
      req_tready = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = !status.rsp_busy;
            cmd.load   = req_tvalid && !status.rsp_busy;
            if (cmd.load) state_in = S_RD_A;
         end
         S_RD_A: state_in = S_RD_B;
         S_RD_B: begin
            cmd.rd_sel = RD_SECOND;
            cmd.cap_a  = 1'b1;
            state_in   = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            priority if (status.long_div) state_in = S_DIV;
            else if (status.long_rev)     state_in = S_REV_CHK;
            else                          state_in = S_IDLE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_DIV_WR;
         end
         S_DIV_WR: begin
            cmd.div_wr = 1'b1;
            state_in   = S_IDLE;
         end
         S_REV_CHK: begin
            if (status.rev_more) begin
               state_in = S_REV_RD1;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_REV_RD1: begin
            cmd.rd_sel = RD_LO;
            state_in   = S_REV_RD2;
         end
         S_REV_RD2: begin
            cmd.rd_sel  = RD_HI;
            cmd.rev_cap = 1'b1;
            state_in    = S_REV_W1;
         end
         S_REV_W1: begin
            cmd.rev_w1 = 1'b1;
            state_in   = S_REV_W2;
         end
         S_REV_W2: begin
            cmd.rev_w2 = 1'b1;
            state_in   = S_REV_CHK;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/smx_datapath.sv =====
// Stack memory, machine registers, ALU, serial divider and result register.
module smx_datapath
   import smx_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int PROG_DEPTH  = DEF_PROG_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  smx_cmd_type    cmd,
   output smx_status_type status,
   input  logic [4:0]     in_command,
   input  logic [31:0]    in_immediate,
   input  logic [9:0]     in_target,
   input  logic [1:0]     in_reverse_mode,
   input  logic [31:0]    in_read_value,
   input  logic           csr_we,
   input  logic [9:0]     csr_wdata,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [9:0]     out_next_pc,
   output logic           out_valid,
   output logic [31:0]    out_value,
   output logic           out_halted,
   output logic [2:0]     out_error
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int PW = $clog2(PROG_DEPTH);

   function automatic logic [9:0] pc_field(input logic [PW-1:0] p);
      logic [31:0] w;
      w = 32'(p);
      return w[9:0];
   endfunction

   // latched instruction
   logic [4:0]    cmd_ff;
   logic [31:0]   imm_ff;
   logic [PW-1:0] tgt_ff;
   logic [1:0]    mode_ff;
   logic [31:0]   rv_ff;

   // machine state
   logic [CW-1:0] cnt_ff;
   logic [PW-1:0] pc_ff;
   logic          halt_ff;
   logic [2:0]    err_ff;

   // stack memory
   logic [31:0]   mem [STACK_DEPTH];
   logic [31:0]   rd_q_ff;
   logic [AW-1:0] rd_addr;
   logic          we;
   logic [AW-1:0] wa;
   logic [31:0]   wd;

   logic [31:0]   a_ff;
   logic [31:0]   tmp_ff;
   logic [CW-1:0] lo_ff;
   logic [CW-1:0] hi_ff;

   // divider
   logic [31:0]   q_ff;
   logic [31:0]   rem_ff;
   logic [31:0]   ub_ff;
   logic          neg_ff;
   logic [4:0]    step_ff;
   logic [32:0]   rem_sh;
   logic [32:0]   rem_sub;
   logic          rem_ge;
   logic [31:0]   quot;

   // result register
   logic          rsp_valid_ff;
   logic [9:0]    o_pc_ff;
   logic          o_valid_ff;
   logic [31:0]   o_value_ff;
   logic          o_halt_ff;
   logic [2:0]    o_err_ff;

   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] cnt_m2;
   logic [CW-1:0] hi_m1;
   logic [31:0]   b;
   logic [31:0]   pc_p1;
   logic [PW-1:0] pc_inc;
   logic          full;

   // execute decode
   logic [2:0]    ex_err;
   logic          ex_push;
   logic          ex_pop1;
   logic          ex_wr2;
   logic [31:0]   ex_val;
   logic          ex_out_valid;
   logic [PW-1:0] ex_pc;
   logic          ex_halt;
   logic          ex_div;
   logic          ex_rev;
   logic [CW-1:0] ex_lo;
   logic [CW-1:0] ex_hi;
   logic          long_op;
   logic          load_out;

   assign cnt_m1 = cnt_ff - CW'(1);
   assign cnt_m2 = cnt_ff - CW'(2);
   assign hi_m1  = hi_ff - CW'(1);
   assign b      = rd_q_ff;
   assign pc_p1  = 32'(pc_ff) + 32'd1;
   assign pc_inc = (pc_p1 == 32'(PROG_DEPTH)) ? '0 : pc_p1[PW-1:0];
   assign full   = (cnt_ff == CW'(STACK_DEPTH));

   always_comb begin
      ex_err       = ERR_NONE;
      ex_push      = 1'b0;
      ex_pop1      = 1'b0;
      ex_wr2       = 1'b0;
      ex_val       = '0;
      ex_out_valid = 1'b0;
      ex_pc        = pc_inc;
      ex_halt      = 1'b0;
      ex_div       = 1'b0;
      ex_rev       = 1'b0;
      ex_lo        = '0;
      ex_hi        = cnt_ff;
      unique case (cmd_ff)
         CMD_READ, CMD_DUPE, CMD_PUSH, CMD_CALL, CMD_SIZE, CMD_EMPTY: begin
            priority if (cmd_ff == CMD_DUPE && cnt_ff == '0) ex_err = ERR_UNDERFLOW;
            else if (full) ex_err = ERR_OVERFLOW;
            else ex_push = 1'b1;
            unique case (cmd_ff)
               CMD_READ: ex_val = rv_ff;
               CMD_DUPE: ex_val = a_ff;
               CMD_PUSH: ex_val = imm_ff;
               CMD_CALL: begin
                  ex_val = 32'(pc_inc);
                  ex_pc  = tgt_ff;
               end
               CMD_SIZE: ex_val = 32'(cnt_ff);
               default:  ex_val = 32'(cnt_ff == '0);
            endcase
         end
         CMD_WRITE: begin
            if (cnt_ff == '0) begin
               ex_err = ERR_UNDERFLOW;
            end else begin
               ex_pop1      = 1'b1;
               ex_out_valid = 1'b1;
               ex_val       = a_ff;
            end
         end
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_AND, CMD_OR, CMD_XOR: begin
            priority if (cnt_ff < CW'(2)) ex_err = ERR_UNDERFLOW;
            else if (cmd_ff == CMD_DIV && b == '0) ex_err = ERR_DIV_ZERO;
            else if (cmd_ff == CMD_DIV) ex_div = 1'b1;
            else ex_wr2 = 1'b1;
            unique case (cmd_ff)
               CMD_ADD: ex_val = a_ff + b;
               CMD_SUB: ex_val = a_ff - b;
               CMD_MUL: ex_val = a_ff * b;
               CMD_AND: ex_val = a_ff & b;
               CMD_OR:  ex_val = a_ff | b;
               default: ex_val = a_ff ^ b;
            endcase
         end
         CMD_REVERSE: begin
            if (mode_ff == REV_POPPED) begin
               priority if (cnt_ff == '0) ex_err = ERR_UNDERFLOW;
               else if (a_ff > 32'(cnt_m1)) ex_err = ERR_UNDERFLOW;
               else begin
                  ex_rev  = 1'b1;
                  ex_pop1 = 1'b1;
                  ex_lo   = cnt_m1 - a_ff[CW-1:0];
                  ex_hi   = cnt_m1;
               end
            end else if (mode_ff == REV_IMM) begin
               if (imm_ff > 32'(cnt_ff)) begin
                  ex_err = ERR_UNDERFLOW;
               end else begin
                  ex_rev = 1'b1;
                  ex_lo  = cnt_ff - imm_ff[CW-1:0];
               end
            end else begin
               ex_rev = 1'b1;
            end
         end
         CMD_JEQ, CMD_JGT: begin
            if (cnt_ff == '0) begin
               ex_err = ERR_UNDERFLOW;
            end else begin
               ex_pop1 = 1'b1;
               if (cmd_ff == CMD_JEQ ? (a_ff == '0) : (a_ff != '0 && !a_ff[31]))
                  ex_pc = tgt_ff;
            end
         end
         CMD_JMP: ex_pc = tgt_ff;
         CMD_RET: begin
            priority if (cnt_ff == '0) ex_err = ERR_UNDERFLOW;
            else if (a_ff >= 32'(PROG_DEPTH)) ex_err = ERR_BAD_RET;
            else begin
               ex_pop1 = 1'b1;
               ex_pc   = a_ff[PW-1:0];
            end
         end
         CMD_HALT: begin
            ex_halt = 1'b1;
            ex_pc   = pc_ff;
         end
         default: ;
      endcase
   end

   assign long_op         = !halt_ff && (ex_div || ex_rev);
   assign status.rsp_busy = rsp_valid_ff;
   assign status.long_div = !halt_ff && ex_div;
   assign status.long_rev = !halt_ff && ex_rev;
   assign status.div_last = (step_ff == 5'd31);
   assign status.rev_more = ({1'b0, hi_ff} > ({1'b0, lo_ff} + (CW + 1)'(1)));

   // restoring divide on magnitudes, one quotient bit a cycle
   assign rem_sh  = {rem_ff, q_ff[31]};
   assign rem_sub = rem_sh - {1'b0, ub_ff};
   assign rem_ge  = (rem_sh >= {1'b0, ub_ff});
   assign quot    = neg_ff ? (32'd0 - q_ff) : q_ff;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_TOP:    rd_addr = cnt_m1[AW-1:0];
         RD_SECOND: rd_addr = cnt_m2[AW-1:0];
         RD_LO:     rd_addr = lo_ff[AW-1:0];
         default:   rd_addr = hi_m1[AW-1:0];
      endcase
   end

   always_comb begin
      we = 1'b0;
      wa = cnt_ff[AW-1:0];
      wd = ex_val;
      priority if (cmd.exec) begin
         we = !halt_ff && ex_err == ERR_NONE && (ex_push || ex_wr2);
         wa = ex_push ? cnt_ff[AW-1:0] : cnt_m2[AW-1:0];
      end else if (cmd.div_wr) begin
         we = 1'b1;
         wa = cnt_m2[AW-1:0];
         wd = quot;
      end else if (cmd.rev_w1) begin
         we = 1'b1;
         wa = lo_ff[AW-1:0];
         wd = rd_q_ff;
      end else if (cmd.rev_w2) begin
         we = 1'b1;
         wa = hi_m1[AW-1:0];
         wd = tmp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_q_ff <= mem[rd_addr];
   end

   assign load_out = (cmd.exec && !long_op) || cmd.div_wr || cmd.finish;

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= in_command;
         imm_ff  <= in_immediate;
         tgt_ff  <= PW'(32'(in_target) % PROG_DEPTH);
         mode_ff <= in_reverse_mode;
         rv_ff   <= in_read_value;
      end
      if (cmd.cap_a) a_ff <= rd_q_ff;
      if (cmd.rev_cap) tmp_ff <= rd_q_ff;
      if (cmd.exec) begin
         lo_ff   <= ex_lo;
         hi_ff   <= ex_hi;
         q_ff    <= a_ff[31] ? (32'd0 - a_ff) : a_ff;
         ub_ff   <= b[31] ? (32'd0 - b) : b;
         neg_ff  <= a_ff[31] ^ b[31];
         rem_ff  <= '0;
         step_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
         q_ff    <= {q_ff[30:0], rem_ge};
         step_ff <= step_ff + 5'd1;
      end
      if (cmd.rev_w2) begin
         lo_ff <= lo_ff + CW'(1);
         hi_ff <= hi_m1;
      end
      if (load_out) begin
         if (cmd.exec && !halt_ff && ex_err == ERR_NONE) begin
            o_pc_ff    <= pc_field(ex_pc);
            o_valid_ff <= ex_out_valid;
            o_value_ff <= ex_out_valid ? ex_val : '0;
            o_halt_ff  <= ex_halt;
            o_err_ff   <= err_ff;
         end else begin
            // halted, faulting, or the end of a divide or reverse
            o_pc_ff    <= pc_field(pc_ff);
            o_valid_ff <= 1'b0;
            o_value_ff <= '0;
            o_halt_ff  <= halt_ff || cmd.exec;
            o_err_ff   <= (cmd.exec && !halt_ff) ? ex_err : err_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) pc_ff <= PW'(32'(csr_wdata) % PROG_DEPTH);
         if (cmd.exec && !halt_ff) begin
            if (ex_err != ERR_NONE) begin
               err_ff  <= ex_err;
               halt_ff <= 1'b1;
            end else begin
               pc_ff <= ex_pc;
               if (ex_halt) halt_ff <= 1'b1;
               priority if (ex_push) cnt_ff <= cnt_ff + CW'(1);
               else if (ex_pop1 || ex_wr2) cnt_ff <= cnt_m1;
            end
         end
         if (cmd.div_wr) cnt_ff <= cnt_m1;
         priority if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign out_next_pc = o_pc_ff;
   assign out_valid   = o_valid_ff;
   assign out_value   = o_value_ff;
   assign out_halted  = o_halt_ff;
   assign out_error   = o_err_ff;

endmodule

// ===== src/stack_machine_execute.sv =====
// Top level of the stack machine execute unit: stream ports, controller and datapath.
//
// Executes one decoded instruction per request transfer and answers with exactly one
// response transfer (next fetch address, write value, halt and error status). Items are
// handled one at a time: a request is taken only when the response register is empty,
// so a new request can follow once the previous response transfer completes. Each
// instruction first does two registered stack reads for the top two operands, then
// executes; divide then runs a one-bit-per-cycle restoring divider, and reverse over k
// elements walks the stack memory with one swap (check, two reads, two writes) per
// pass, floor(k/2) swaps in all. Once halted (halt or any error) instructions are
// answered without effect until reset. The stack memory needs no clearing pass after
// reset; entries are only used below the stack count. csr_wdata sets the program
// counter directly and must be written only while no instruction is in flight.
module stack_machine_execute
   import smx_pkg::*;
#(
   parameter int STACK_DEPTH = DEF_STACK_DEPTH,
   parameter int PROG_DEPTH  = DEF_PROG_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // immediate[31:0], target[41:32], read_value[73:42], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command[4:0], reverse_mode[6:5]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // next_pc[9:0], out_valid[10], out_value[42:11], halted[43], error[46:44], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_W-1:0]      csr_wdata
);

   smx_cmd_type    cmd;
   smx_status_type status;

   logic [9:0]  out_next_pc;
   logic        out_valid;
   logic [31:0] out_value;
   logic        out_halted;
   logic [2:0]  out_error;

   smx_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smx_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .PROG_DEPTH  (PROG_DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .in_command      (req_tuser[4:0]),
      .in_immediate    (req_tdata[31:0]),
      .in_target       (req_tdata[41:32]),
      .in_reverse_mode (req_tuser[6:5]),
      .in_read_value   (req_tdata[73:42]),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .out_next_pc     (out_next_pc),
      .out_valid       (out_valid),
      .out_value       (out_value),
      .out_halted      (out_halted),
      .out_error       (out_error)
   );

   // response fields packed from bit 0 up
   assign rsp_tdata = {1'b0, out_error, out_halted, out_value, out_valid, out_next_pc};

endmodule

// ===== src/smx_checker.sv =====
// Port-level checks of the stack machine execute unit, bound to its top level.
module smx_checker
   import smx_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // one item in flight: no request while a response waits
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request ready while response pending");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request ready right after a request transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[46:44] != ERR_NONE) |-> rsp_tdata[43])
      else $error("error reported without halt");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[10]) |-> (rsp_tdata[42:11] == 32'd0))
      else $error("write value nonzero without out_valid");

endmodule

bind stack_machine_execute smx_checker u_smx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/smx_exec_checker.sv =====
// Checker for the stack machine execute unit: predicts each response and compares it.
module smx_exec_checker
   import smx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [9:0]  next_pc;
      logic        out_valid;
      logic [31:0] out_value;
      logic        halted;
      logic [2:0]  error;
   } exec_result_type;

   logic [31:0]     stack_mem [DEF_STACK_DEPTH];
   int              depth;
   logic [9:0]      pc;
   logic            halted_q;
   logic [2:0]      err_q;
   exec_result_type expected_q[$];

   assign pending = expected_q.size();

   function automatic void flip_stack(int lo, int hi);
      logic [31:0] t;
      while (hi > lo + 1) begin
         t = stack_mem[lo];
         stack_mem[lo] = stack_mem[hi-1];
         stack_mem[hi-1] = t;
         lo++;
         hi--;
      end
   endfunction

   function automatic exec_result_type execute_instr(logic [4:0] cmd, logic [31:0] imm,
                                                     logic [9:0] tgt, logic [1:0] mode,
                                                     logic [31:0] rv);
      exec_result_type r;
      logic [31:0]  a, b, res, x, ua, ub, q;
      int           n;
      logic [9:0]   nxt;
      logic [2:0]   e;
      logic         v;
      logic [31:0]  val;
      n = depth;
      nxt = pc + 10'd1;
      e = ERR_NONE;
      v = 1'b0;
      val = '0;
      a = '0;
      b = '0;
      res = '0;
      if (!halted_q) begin
         if (n >= 1) a = stack_mem[n-1];
         if (n >= 2) b = stack_mem[n-2];
         case (cmd)
            CMD_READ, CMD_DUPE, CMD_PUSH, CMD_CALL, CMD_SIZE, CMD_EMPTY: begin
               if (cmd == CMD_DUPE && n < 1) e = ERR_UNDERFLOW;
               else if (n >= DEF_STACK_DEPTH) e = ERR_OVERFLOW;
               else begin
                  case (cmd)
                     CMD_READ: res = rv;
                     CMD_DUPE: res = a;
                     CMD_PUSH: res = imm;
                     CMD_CALL: res = 32'(nxt);
                     CMD_SIZE: res = 32'(n);
                     default:  res = 32'(n == 0);
                  endcase
                  stack_mem[n] = res;
                  depth = n + 1;
                  if (cmd == CMD_CALL) nxt = tgt;
               end
            end
            CMD_WRITE: begin
               if (n < 1) e = ERR_UNDERFLOW;
               else begin
                  v = 1'b1;
                  val = a;
                  depth = n - 1;
               end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_AND, CMD_OR, CMD_XOR: begin
               if (n < 2) e = ERR_UNDERFLOW;
               else if (cmd == CMD_DIV && b == 0) e = ERR_DIV_ZERO;
               else begin
                  case (cmd)
                     CMD_ADD: res = a + b;
                     CMD_SUB: res = a - b;
                     CMD_MUL: res = a * b;
                     CMD_DIV: begin
                        // sign-magnitude, truncates toward zero; INT_MIN / -1 wraps
                        ua = a[31] ? -a : a;
                        ub = b[31] ? -b : b;
                        q = ua / ub;
                        res = (a[31] ^ b[31]) ? -q : q;
                     end
                     CMD_AND: res = a & b;
                     CMD_OR:  res = a | b;
                     default: res = a ^ b;
                  endcase
                  stack_mem[n-2] = res;
                  depth = n - 1;
               end
            end
            CMD_REVERSE: begin
               if (mode == REV_POPPED) begin
                  if (n < 1) e = ERR_UNDERFLOW;
                  else begin
                     x = a;
                     if (x > 32'(n - 1)) e = ERR_UNDERFLOW;
                     else begin
                        n = n - 1;
                        depth = n;
                        flip_stack(n - int'(x), n);
                     end
                  end
               end else if (mode == REV_IMM) begin
                  if (imm > 32'(n)) e = ERR_UNDERFLOW;
                  else flip_stack(n - int'(imm), n);
               end else flip_stack(0, n);
            end
            CMD_JEQ, CMD_JGT: begin
               if (n < 1) e = ERR_UNDERFLOW;
               else begin
                  depth = n - 1;
                  if (cmd == CMD_JEQ ? (a == 0) : (a != 0 && !a[31])) nxt = tgt;
               end
            end
            CMD_JMP: nxt = tgt;
            CMD_RET: begin
               if (n < 1) e = ERR_UNDERFLOW;
               else if (a >= 32'(DEF_PROG_DEPTH)) e = ERR_BAD_RET;
               else begin
                  depth = n - 1;
                  nxt = a[9:0];
               end
            end
            CMD_HALT: begin
               halted_q = 1'b1;
               nxt = pc;
            end
            default: ;
         endcase
         if (e != ERR_NONE) begin
            err_q = e;
            halted_q = 1'b1;
            v = 1'b0;
            val = '0;
         end else pc = nxt;
      end
      r.next_pc = pc;
      r.out_valid = v;
      r.out_value = val;
      r.halted = halted_q;
      r.error = err_q;
      return r;
   endfunction

   always @(posedge clock) begin
      exec_result_type want, got;
      if (reset) begin
         foreach (stack_mem[i]) stack_mem[i] = '0;
         depth = 0;
         pc = '0;
         halted_q = 1'b0;
         err_q = ERR_NONE;
         fail_count = 0;
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.next_pc = rsp_tdata[9:0];
            got.out_valid = rsp_tdata[10];
            got.out_value = rsp_tdata[42:11];
            got.halted = rsp_tdata[43];
            got.error = rsp_tdata[46:44];
            if (expected_q.size() == 0) begin
               $error("response transfer with nothing expected");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (got.next_pc !== want.next_pc) begin
                  $error("next_pc expected %0d got %0d", want.next_pc, got.next_pc);
                  fail_count++;
               end
               if (got.out_valid !== want.out_valid) begin
                  $error("out_valid expected %0d got %0d", want.out_valid, got.out_valid);
                  fail_count++;
               end
               if (got.out_value !== want.out_value) begin
                  $error("out_value expected %h got %h", want.out_value, got.out_value);
                  fail_count++;
               end
               if (got.halted !== want.halted) begin
                  $error("halted expected %0d got %0d", want.halted, got.halted);
                  fail_count++;
               end
               if (got.error !== want.error) begin
                  $error("error expected %0d got %0d", want.error, got.error);
                  fail_count++;
               end
            end
         end
         if (csr_we) pc = csr_wdata;
         if (req_tvalid && req_tready)
            expected_q.push_back(execute_instr(req_tuser[4:0], req_tdata[31:0],
                                               req_tdata[41:32], req_tuser[6:5],
                                               req_tdata[73:42]));
      end
   end

endmodule

// ===== bench/stack_machine_execute_tb.sv =====
// Testbench top for the stack machine execute unit: stimulus, watchdog and verdict.
module stack_machine_execute_tb
   import smx_pkg::*;
();

   localparam int IDLE_LIMIT = 5000;   // reverse of a full stack plus the long hold-off fit well inside
   localparam int HOLD_LEN   = 300;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;    // immediate, target, read_value, zero pad
   logic [REQ_USER_W-1:0] req_tuser;    // command, reverse_mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;    // next_pc, out_valid, out_value, halted, error
   logic                  csr_we;
   logic [CSR_W-1:0]      csr_wdata;
   int                    fail_count;
   int                    pending;
   int                    depth;        // stack depth as seen by the generator
   int                    idle_cycles;
   bit                    hold_off;
   bit                    hold_done;
   bit                    tx_burst;
   bit                    rx_burst;

   stack_machine_execute dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   smx_exec_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'h1;
         2: return 32'hFFFF_FFFF;
         3: return 32'h7FFF_FFFF;
         4: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // one request transfer; the gap before it is drawn per item
   task automatic send(logic [4:0] cmd, logic [31:0] imm, logic [9:0] tgt,
                       logic [1:0] mode, logic [31:0] rv);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, rv, tgt, imm};
      req_tuser <= {mode, cmd};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      case (cmd)
         CMD_READ, CMD_DUPE, CMD_PUSH, CMD_CALL, CMD_SIZE, CMD_EMPTY: depth++;
         CMD_WRITE, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_AND, CMD_OR, CMD_XOR,
         CMD_JEQ, CMD_JGT, CMD_RET: depth--;
         CMD_REVERSE: if (mode == REV_POPPED) depth--;
         default: ;
      endcase
      if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
   endtask

   task automatic op(logic [4:0] cmd, logic [31:0] imm);
      send(cmd, imm, 10'($urandom), 2'($urandom), $urandom);
   endtask

   task automatic push(logic [31:0] v);
      op(CMD_PUSH, v);
   endtask

   // sender pause until every response is back, then a write of start_address
   task automatic drain_and_config(logic [9:0] addr);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (4) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= addr;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // one short well-formed sequence that cannot fault
   task automatic random_sequence();
      logic [4:0] cmd;
      int k;
      if (depth > 200) begin
         op(CMD_WRITE, $urandom);
         return;
      end
      case ($urandom_range(0, 13))
         0: push(rand_word());
         1: send(CMD_READ, $urandom, 10'($urandom), 2'($urandom), rand_word());
         2: begin
            if (depth < 1) push(rand_word());
            op(CMD_DUPE, $urandom);
         end
         3: op($urandom_range(0, 1) ? CMD_SIZE : CMD_EMPTY, $urandom);
         4: begin
            if (depth < 1) push(rand_word());
            op(CMD_WRITE, $urandom);
         end
         5: begin
            if ($urandom_range(0, 1)) push(rand_word());
            while (depth < 2) push(rand_word());
            cmd = 5'($urandom_range(CMD_ADD, CMD_XOR));
            if (cmd == CMD_DIV) cmd = CMD_SUB;   // divide has its own arm below
            op(cmd, $urandom);
         end
         6: begin
            // divide: nonzero divisor below the dividend
            k = $urandom_range(0, 3);
            push(k == 0 ? 32'hFFFF_FFFF : (k == 1 ? 32'(-$urandom_range(1, 9)) :
                 ($urandom | 32'h1)));
            push($urandom_range(0, 3) == 0 ? 32'h8000_0000 : rand_word());
            op(CMD_DIV, $urandom);
         end
         7: begin
            k = $urandom_range(0, 2);
            if (k == 0) send(CMD_REVERSE, $urandom, 10'($urandom),
                             $urandom_range(0, 1) ? 2'd0 : 2'd3, $urandom);
            else if (k == 1) send(CMD_REVERSE, $urandom_range(0, depth),
                                  10'($urandom), REV_IMM, $urandom);
            else begin
               push($urandom_range(0, depth));
               send(CMD_REVERSE, $urandom, 10'($urandom), REV_POPPED, $urandom);
            end
         end
         8: begin
            if (depth < 1 || $urandom_range(0, 1)) push($urandom_range(0, 1) ? 32'h0 : rand_word());
            op($urandom_range(0, 1) ? CMD_JEQ : CMD_JGT, $urandom);
         end
         9:  op(CMD_JMP, $urandom);
         10: op(CMD_CALL, $urandom);
         11: begin
            push($urandom_range(0, DEF_PROG_DEPTH - 1));
            op(CMD_RET, $urandom);
         end
         12: op(5'($urandom_range(20, 31)), $urandom);   // unknown codes only advance pc
         default: push($urandom);
      endcase
   endtask

   // receiver: per-item stall, and one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      rx_burst = 1'b0;
      hold_done = 1'b0;
      @(negedge reset);
      forever begin
         int stall;
         stall = rx_burst ? 0 : $urandom_range(0, 16);
         if (hold_off && !hold_done) begin
            stall = HOLD_LEN;
            hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
         if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      hold_off = 1'b0;
      tx_burst = 1'b0;
      depth = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      drain_and_config(10'd1023);

      // directed: field extremes, every operation but halt, wrap and sign corners
      op(CMD_EMPTY, 32'h0);                        // empty on empty stack
      push(32'h7FFF_FFFF);
      push(32'h0000_0001);
      op(CMD_ADD, 32'h0);                          // wraps to INT_MIN
      push(32'hFFFF_FFFF);
      push(32'h8000_0000);
      op(CMD_DIV, 32'h0);                          // INT_MIN / -1
      push(32'h0000_0002);
      push(32'hFFFF_FFF9);
      op(CMD_DIV, 32'h0);                          // -7 / 2 truncates to -3
      op(CMD_MUL, 32'h0);
      op(CMD_SUB, 32'h0);
      send(CMD_READ, 32'h0, 10'h3FF, 2'd3, 32'hFFFF_FFFF);
      op(CMD_DUPE, 32'h0);
      op(CMD_AND, 32'h0);
      send(CMD_READ, 32'hFFFF_FFFF, 10'h0, 2'd0, 32'h0);
      op(CMD_OR, 32'h0);
      op(CMD_XOR, 32'h0);
      op(CMD_SIZE, 32'h0);
      send(CMD_REVERSE, 32'h0, 10'h0, 2'd3, 32'h0);  // mode three, whole stack
      send(CMD_REVERSE, 32'h2, 10'h0, REV_IMM, 32'h0);
      push(32'h1);
      send(CMD_REVERSE, 32'h0, 10'h0, REV_POPPED, 32'h0);
      send(CMD_CALL, 32'h0, 10'h3FF, 2'd0, 32'h0);
      op(CMD_RET, 32'h0);
      send(CMD_JMP, 32'h0, 10'h3FF, 2'd0, 32'h0);
      op(5'd31, 32'h0);                            // unknown code, pc wraps
      send(CMD_JEQ, 32'h0, 10'h155, 2'd0, 32'h0);
      send(CMD_JGT, 32'h0, 10'h2AA, 2'd0, 32'h0);
      op(CMD_WRITE, 32'h0);

      drain_and_config(10'd0);
      repeat (240) random_sequence();

      drain_and_config(10'($urandom));
      hold_off = 1'b1;                             // receiver backs up, block stalls input
      repeat (240) random_sequence();

      drain_and_config(10'd512);
      repeat (220) random_sequence();

      // ending: one terminal event per run, then items while halted
      case ($urandom_range(0, 4))
         0: op(CMD_HALT, $urandom);
         1: begin
            while (depth > 0) op(CMD_WRITE, $urandom);
            op($urandom_range(0, 1) ? CMD_WRITE : CMD_ADD, $urandom);
         end
         2: begin
            while (depth < DEF_STACK_DEPTH) push($urandom);
            push($urandom);
         end
         3: begin
            push(32'h0);
            push(rand_word());
            op(CMD_DIV, $urandom);
         end
         default: begin
            push($urandom_range(0, 1) ? 32'(DEF_PROG_DEPTH) : 32'hFFFF_FFFF);
            op(CMD_RET, $urandom);
         end
      endcase
      repeat (4) random_sequence();
      op(CMD_HALT, $urandom);

      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (50) @(negedge clock);
      if (fail_count == 0 && pending == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
